>>> rtl/body_whole_word_counter_defines.svh
// Assertion macros for the body whole-word counter.
// Used by the top level; needs clk_i and rst_ni in the asserting scope.
`ifndef BODY_WHOLE_WORD_COUNTER_DEFINES_SVH
`define BODY_WHOLE_WORD_COUNTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BWWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a non-overlapping implication outside reset.
`define BWWC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/bwwc_pkg.sv
// Shared constants, codes and character helpers for the body whole-word counter.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package bwwc_pkg;

  localparam int MAX_WORD_LEN    = 12;
  localparam int COUNT_BITS      = 16;
  localparam int WORD_COUNT_BITS = 16;
  localparam int WORD_LOW_BITS   = 64;
  localparam int WORD_HIGH_BITS  = 32;
  localparam int WORD_CHAR_BITS  = WORD_LOW_BITS + WORD_HIGH_BITS;
  localparam int WORD_LEN_BITS   = 4;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_WORD_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORD_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORD_LEN  = 2'd2;

  // Page region codes.
  localparam logic [1:0] RGN_BEFORE = 2'd0;
  localparam logic [1:0] RGN_INSIDE = 2'd1;
  localparam logic [1:0] RGN_AFTER  = 2'd2;

  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_GT = 8'h3E;

  localparam logic [2:0] OPEN_TAG_LEN  = 3'd6;
  localparam logic [2:0] CLOSE_TAG_END = 3'd6;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if ((c >= 8'h41) && (c <= 8'h5A)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // "<body>"
  function automatic logic [7:0] open_tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h62;
      3'd2:    ch = 8'h6F;
      3'd3:    ch = 8'h64;
      3'd4:    ch = 8'h79;
      3'd5:    ch = 8'h3E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "</body>"
  function automatic logic [7:0] close_tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h3C;
      3'd1:    ch = 8'h2F;
      3'd2:    ch = 8'h62;
      3'd3:    ch = 8'h6F;
      3'd4:    ch = 8'h64;
      3'd5:    ch = 8'h79;
      3'd6:    ch = 8'h3E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] word_char(input logic [WORD_CHAR_BITS-1:0] chars,
                                           input logic [WORD_LEN_BITS-1:0] idx);
    if (int'(idx) < MAX_WORD_LEN) begin
      return fold_char(chars[8*int'(idx) +: 8]);
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bwwc_if.sv
// Handshake channels of the body whole-word counter: page bytes in,
// counts out, register writes. Depends on bwwc_pkg.
`default_nettype none

interface bwwc_page_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       page_end;

  modport source (output valid, output page_byte, output page_end, input ready);
  modport sink   (input valid, input page_byte, input page_end, output ready);
endinterface

interface bwwc_count_if;
  logic                                 valid;
  logic                                 ready;
  logic [bwwc_pkg::WORD_COUNT_BITS-1:0] word_count;
  logic                                 body_seen;

  modport source (output valid, output word_count, output body_seen, input ready);
  modport sink   (input valid, input word_count, input body_seen, output ready);
endinterface

interface bwwc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bwwc_pkg::CFG_IDX_BITS-1:0]  reg_index;
  logic [bwwc_pkg::CFG_DATA_BITS-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

`default_nettype wire

>>> rtl/body_whole_word_counter.sv
// Body whole-word counter: one page byte a cycle while not stalled, one count per page.
// A page's count passes through the input register and the result register to the count port.
// Input stalls only when a page's last byte waits behind a count held at a busy port.
// Per-byte work is the tag match and word compare between input and state registers.
// Reset clears per-page state and sets the search word to empty with length 1.
// Depends on bwwc_pkg, bwwc_if and body_whole_word_counter_defines.svh.
`default_nettype none
`include "body_whole_word_counter_defines.svh"

module body_whole_word_counter (
  input  wire               clk_i,
  input  wire               rst_ni,
  bwwc_page_if.sink         page_i,
  bwwc_cfg_if.sink          cfg_i,
  bwwc_count_if.source      count_o
);

  // Configuration.
  logic [bwwc_pkg::WORD_LOW_BITS-1:0]  word_low_q;
  logic [bwwc_pkg::WORD_HIGH_BITS-1:0] word_high_q;
  logic [bwwc_pkg::WORD_LEN_BITS-1:0]  word_len_q;
  logic [bwwc_pkg::WORD_CHAR_BITS-1:0] word_chars;

  assign cfg_i.ready = 1'b1;
  assign word_chars  = {word_high_q, word_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_low_q  <= '0;
      word_high_q <= '0;
      word_len_q  <= bwwc_pkg::WORD_LEN_BITS'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        bwwc_pkg::REG_WORD_LOW:  word_low_q  <= cfg_i.reg_data;
        bwwc_pkg::REG_WORD_HIGH: word_high_q <= cfg_i.reg_data[bwwc_pkg::WORD_HIGH_BITS-1:0];
        bwwc_pkg::REG_WORD_LEN:  word_len_q  <= cfg_i.reg_data[bwwc_pkg::WORD_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       in_fire;
  logic       out_valid_q;

  assign in_fire      = in_valid_q && !(in_end_q && out_valid_q && !count_o.ready);
  assign page_i.ready = !in_valid_q || in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (page_i.ready) begin
      in_valid_q <= page_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (page_i.valid && page_i.ready) begin
      in_byte_q <= page_i.page_byte;
      in_end_q  <= page_i.page_end;
    end
  end

  // Page state.
  logic [1:0]                         region_q, region_d;
  logic [2:0]                         open_pos_q, open_pos_d;
  logic [2:0]                         close_pos_q, close_pos_d;
  logic [bwwc_pkg::WORD_LEN_BITS-1:0] letter_pos_q, letter_pos_d;
  logic                               agree_q, agree_d;
  logic [bwwc_pkg::COUNT_BITS-1:0]    count_q, count_d;

  logic       letter;
  logic [7:0] ch;
  logic       closing;
  logic       len_ok;
  logic       hit;
  logic [31:0] count_ext;

  assign letter = bwwc_pkg::is_letter(in_byte_q);
  assign ch     = bwwc_pkg::fold_char(in_byte_q);
  assign len_ok = (word_len_q != '0) && (int'(word_len_q) <= bwwc_pkg::MAX_WORD_LEN);

  always_comb begin
    region_d     = region_q;
    open_pos_d   = open_pos_q;
    close_pos_d  = close_pos_q;
    letter_pos_d = letter_pos_q;
    agree_d      = agree_q;
    closing      = 1'b0;
    hit          = 1'b0;

    unique case (region_q)
      bwwc_pkg::RGN_BEFORE: begin
        if ((open_pos_q < bwwc_pkg::OPEN_TAG_LEN) &&
            (ch == bwwc_pkg::open_tag_char(open_pos_q))) begin
          open_pos_d = open_pos_q + 3'd1;
        end else begin
          open_pos_d = (ch == bwwc_pkg::CHAR_LT) ? 3'd1 : 3'd0;
        end
        if (open_pos_d == bwwc_pkg::OPEN_TAG_LEN) begin
          region_d     = bwwc_pkg::RGN_INSIDE;
          open_pos_d   = 3'd0;
          letter_pos_d = '0;
          agree_d      = 1'b1;
        end
      end
      bwwc_pkg::RGN_INSIDE: begin
        closing = (close_pos_q == bwwc_pkg::CLOSE_TAG_END) && (ch == bwwc_pkg::CHAR_GT);
        if (ch == bwwc_pkg::close_tag_char(close_pos_q)) begin
          close_pos_d = close_pos_q + 3'd1;
        end else begin
          close_pos_d = (ch == bwwc_pkg::CHAR_LT) ? 3'd1 : 3'd0;
        end
        if (letter) begin
          if (!((letter_pos_q < word_len_q) &&
                (ch == bwwc_pkg::word_char(word_chars, letter_pos_q)))) begin
            agree_d = 1'b0;
          end
          if (letter_pos_q != '1) begin
            letter_pos_d = letter_pos_q + bwwc_pkg::WORD_LEN_BITS'(1);
          end
          // A word running into the page's last byte is complete.
          hit = in_end_q && agree_d && (letter_pos_d == word_len_q) && len_ok;
        end else begin
          hit = !closing && agree_q && (letter_pos_q != '0) &&
                (letter_pos_q == word_len_q) && len_ok;
          letter_pos_d = '0;
          agree_d      = 1'b1;
          if (closing) begin
            region_d    = bwwc_pkg::RGN_AFTER;
            close_pos_d = 3'd0;
          end
        end
      end
      default: ;
    endcase

    count_d = (hit && (count_q != bwwc_pkg::COUNT_MAX)) ?
              count_q + bwwc_pkg::COUNT_BITS'(1) : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q     <= bwwc_pkg::RGN_BEFORE;
      open_pos_q   <= '0;
      close_pos_q  <= '0;
      letter_pos_q <= '0;
      agree_q      <= 1'b1;
      count_q      <= '0;
    end else if (in_fire) begin
      if (in_end_q) begin
        region_q     <= bwwc_pkg::RGN_BEFORE;
        open_pos_q   <= '0;
        close_pos_q  <= '0;
        letter_pos_q <= '0;
        agree_q      <= 1'b1;
        count_q      <= '0;
      end else begin
        region_q     <= region_d;
        open_pos_q   <= open_pos_d;
        close_pos_q  <= close_pos_d;
        letter_pos_q <= letter_pos_d;
        agree_q      <= agree_d;
        count_q      <= count_d;
      end
    end
  end

  // Result register.
  logic [bwwc_pkg::WORD_COUNT_BITS-1:0] word_count_q;
  logic                                 body_seen_q;

  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && in_end_q) begin
      out_valid_q <= 1'b1;
    end else if (count_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_end_q) begin
      word_count_q <= (count_ext > 32'h0000_FFFF) ? '1
                                                   : count_ext[bwwc_pkg::WORD_COUNT_BITS-1:0];
      body_seen_q  <= (region_d != bwwc_pkg::RGN_BEFORE);
    end
  end

  assign count_o.valid      = out_valid_q;
  assign count_o.word_count = word_count_q;
  assign count_o.body_seen  = body_seen_q;

  `BWWC_ASSERT(a_tag_pos_range,
    (open_pos_q < bwwc_pkg::OPEN_TAG_LEN) && (close_pos_q <= bwwc_pkg::CLOSE_TAG_END),
    "tag match position out of range")
  `BWWC_ASSERT(a_stall_cause,
    !(in_valid_q && !in_fire) || (in_end_q && out_valid_q && !count_o.ready),
    "input stage held without a blocked count")
  `BWWC_ASSERT_NEXT(a_after_holds,
    (region_q == bwwc_pkg::RGN_AFTER) && !(in_fire && in_end_q),
    region_q == bwwc_pkg::RGN_AFTER, "left after-body region before page end")
  `BWWC_ASSERT_NEXT(a_count_grows, !(in_fire && in_end_q),
    count_q >= $past(count_q), "match total decreased within a page")
  `BWWC_ASSERT_NEXT(a_page_end_result, in_fire && in_end_q,
    out_valid_q && (region_q == bwwc_pkg::RGN_BEFORE) && (count_q == '0),
    "page end did not load a count and clear state")

endmodule

`default_nettype wire
